FILE: design/sfpw_pkg.sv
// ----------------------------------------------------------------------------
// sfpw_pkg
// shared constants and types for the spi flash page writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfpw_pkg;

  // bytes in one flash page, 1 to 256
  localparam int PAGE_BYTES = 128;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W = 24;

  // flash opcodes
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_WRDI = 8'h04;

  // one classified data byte, as handed from front to back
  typedef struct packed {
    logic [7:0]        data;
    logic              first;
    logic              closing;
    logic [ADDR_W-1:0] addr;
  } desc_t;

endpackage

FILE: design/spi_flash_page_writer_unit.sv
// ----------------------------------------------------------------------------
// spi_flash_page_writer_unit
// page-program sequencer for a mode-0 spi flash, one mosi bit per transfer
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+-------------------------------
// data    | in        | data_valid / data_stall | data_byte[7:0]
// bit     | out       | bit_valid / bit_stall   | mosi_bit, frame_end, last
//
// one output bit per clock unless bit_stall holds a shown bit or the queue is
// empty; a mid-page byte sends its data, a page's first byte write enable, page
// program, 3 address bytes and data, the last data and write disable
// a two-entry queue lets new bytes be taken while the serializer is busy
// synchronous reset clears page address, page position, queue and output
// bit_stall freezes a shown output bit and the serializer; data_stall rises only
// when the queue is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_flash_page_writer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  output logic       bit_valid,
  input  logic       bit_stall,
  output logic       mosi_bit,
  output logic       frame_end,
  output logic       last
);

  sfpw_pkg::desc_t  front_desc;
  sfpw_pkg::desc_t  q_head;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  logic             take;

  // byte transfer happens whenever data_valid is high and the queue has room
  assign data_stall = q_full;
  assign take       = data_valid && !q_full;

  // front: page position and address, first / closing classification
  sfpw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .desc      (front_desc)
  );

  // decoupling queue
  sfpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_desc (front_desc),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // back: frame serializer with registered output
  sfpw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_valid   (q_not_empty),
    .pop       (q_pop),
    .bit_valid (bit_valid),
    .bit_stall (bit_stall),
    .mosi_bit  (mosi_bit),
    .frame_end (frame_end),
    .last      (last)
  );

endmodule

FILE: design/sfpw_front.sv
// ----------------------------------------------------------------------------
// sfpw_front
// accepts page bytes, tracks page position and address, classifies each byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpw_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  output sfpw_pkg::desc_t      desc
);

  logic [7:0]                    byte_position;
  logic [sfpw_pkg::ADDR_W-1:0]   page_address;
  logic                          closing;

  // a position at or past the page end closes the page
  assign closing = ({1'b0, byte_position} + 9'd1) >= 9'(sfpw_pkg::PAGE_BYTES);

  assign desc.data    = data_byte;
  assign desc.first   = (byte_position == 8'd0);
  assign desc.closing = closing;
  assign desc.addr    = page_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
      page_address  <= '0;
    end else if (take) begin
      if (closing) begin
        byte_position <= 8'd0;
        page_address  <= page_address + sfpw_pkg::ADDR_W'(sfpw_pkg::PAGE_BYTES);
      end else begin
        byte_position <= byte_position + 8'd1;
      end
    end
  end

endmodule

FILE: design/sfpw_queue.sv
// ----------------------------------------------------------------------------
// sfpw_queue
// short register queue of classified bytes between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfpw_pkg::desc_t  push_desc,
  input  logic             pop,
  output sfpw_pkg::desc_t  head,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_W = (sfpw_pkg::QUEUE_DEPTH > 1) ? $clog2(sfpw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sfpw_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sfpw_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(sfpw_pkg::QUEUE_DEPTH);

  sfpw_pkg::desc_t   entries [sfpw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue pushed while full");

endmodule

FILE: design/sfpw_back.sv
// ----------------------------------------------------------------------------
// sfpw_back
// serializer: walks the frame bytes of one classified byte, when not stalled one bit a clock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpw_back (
  input  logic             clk,
  input  logic             rst,
  input  sfpw_pkg::desc_t  head,
  input  logic             q_valid,
  output logic             pop,
  output logic             bit_valid,
  input  logic             bit_stall,
  output logic             mosi_bit,
  output logic             frame_end,
  output logic             last
);

  typedef enum logic [2:0] {
    S_WREN,
    S_PP,
    S_A2,
    S_A1,
    S_A0,
    S_DATA,
    S_WRDI
  } slot_t;

  slot_t            slot;
  slot_t            slot_next;
  logic [2:0]       bit_idx;
  logic             busy;
  sfpw_pkg::desc_t  cur;
  logic [7:0]       cur_byte;
  logic             advance;
  logic             final_bit;
  logic             bit_frame_end;

  always_comb begin
    unique case (slot)
      S_WREN:  begin cur_byte = sfpw_pkg::OP_WREN;   slot_next = S_PP;   end
      S_PP:    begin cur_byte = sfpw_pkg::OP_PP;     slot_next = S_A2;   end
      S_A2:    begin cur_byte = cur.addr[23:16];     slot_next = S_A1;   end
      S_A1:    begin cur_byte = cur.addr[15:8];      slot_next = S_A0;   end
      S_A0:    begin cur_byte = cur.addr[7:0];       slot_next = S_DATA; end
      S_DATA:  begin cur_byte = cur.data;            slot_next = S_WRDI; end
      S_WRDI:  begin cur_byte = sfpw_pkg::OP_WRDI;   slot_next = S_WRDI; end
      default: begin cur_byte = cur.data;            slot_next = S_DATA; end
    endcase
  end

  assign advance   = busy && (!bit_valid || !bit_stall);
  assign final_bit = (bit_idx == 3'd0) &&
                     ((slot == S_WRDI) || ((slot == S_DATA) && !cur.closing));
  assign bit_frame_end = (bit_idx == 3'd0) &&
                         ((slot == S_WREN) || (slot == S_WRDI) ||
                          ((slot == S_DATA) && cur.closing));
  // take the next byte when idle or on the last bit of the current one
  assign pop = q_valid && (!busy || (advance && final_bit));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bit_valid <= 1'b0;
      slot      <= S_DATA;
      bit_idx   <= 3'd7;
    end else begin
      if (advance) begin
        bit_valid <= 1'b1;
        mosi_bit  <= cur_byte[bit_idx];
        frame_end <= bit_frame_end;
        last      <= final_bit;
      end else if (!bit_stall) begin
        bit_valid <= 1'b0;
      end

      if (pop) begin
        cur     <= head;
        slot    <= head.first ? S_WREN : S_DATA;
        bit_idx <= 3'd7;
        busy    <= 1'b1;
      end else if (advance) begin
        if (bit_idx == 3'd0) begin
          if (final_bit) begin
            busy <= 1'b0;
          end
          slot    <= slot_next;
          bit_idx <= 3'd7;
        end else begin
          bit_idx <= bit_idx - 3'd1;
        end
      end
    end
  end

  a_wrdi_ends_item: assert property (@(posedge clk) disable iff (rst)
    (advance && (bit_idx == 3'd0) && (slot == S_WRDI)) |=>
      (bit_valid && last && frame_end))
    else $error("write-disable frame did not close the item");

  a_mid_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && (bit_idx != 3'd0)) |=> (!last && !frame_end))
    else $error("frame or item end flagged inside a byte");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (bit_valid && bit_stall) |=>
      (bit_valid && $stable(mosi_bit) && $stable(frame_end) && $stable(last)))
    else $error("output bit changed under stall");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives page bytes into spi_flash_page_writer_unit and checks the serial
// bit stream against a local predictor of frames, opcodes and page address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // worst case is far below this: 48 bits per page opening, each after a random
  // receiver stall, plus sender gaps and one long receiver hold
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 600;

  // one expected serial bit
  typedef struct packed {
    logic mosi;
    logic frame_end;
    logic last;
  } spi_bit_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       data_valid = 1'b0;
  logic       data_stall;
  logic [7:0] data_byte = 8'h00;
  logic       bit_valid;
  logic       bit_stall = 1'b0;
  logic       mosi_bit;
  logic       frame_end;
  logic       last;

  // predictor state: current page address and position within the page
  logic [sfpw_pkg::ADDR_W-1:0] page_addr_now = '0;
  logic [7:0]                  page_pos_now = '0;

  spi_bit_t pending_bits[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  // no random gaps on either side while set
  bit  steady = 1'b0;
  // receiver holds off for this many cycles before its next transfer
  int  hold_request = 0;

  spi_flash_page_writer_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .bit_valid  (bit_valid),
    .bit_stall  (bit_stall),
    .mosi_bit   (mosi_bit),
    .frame_end  (frame_end),
    .last       (last)
  );

  always #2 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // queue eight bits of one octet, msb first; frame_end on bit 0 if it closes
  task automatic push_octet(input logic [7:0] value, input logic closes);
    spi_bit_t b;
    for (int i = 7; i >= 0; i--) begin
      b.mosi      = value[i];
      b.frame_end = closes && (i == 0);
      b.last      = 1'b0;
      pending_bits.push_back(b);
    end
  endtask

  // expected bit stream for one accepted page byte
  task automatic serialize_byte(input logic [7:0] value);
    logic opening;
    logic closing;
    opening = (page_pos_now == 8'd0);
    // a position at or past the page end is treated as the closing byte
    closing = (int'(page_pos_now) + 1 >= sfpw_pkg::PAGE_BYTES);
    if (opening) begin
      // write enable stands alone, then page program with the address
      push_octet(sfpw_pkg::OP_WREN, 1'b1);
      push_octet(sfpw_pkg::OP_PP, 1'b0);
      push_octet(page_addr_now[23:16], 1'b0);
      push_octet(page_addr_now[15:8], 1'b0);
      push_octet(page_addr_now[7:0], 1'b0);
    end
    push_octet(value, closing);
    if (closing) begin
      push_octet(sfpw_pkg::OP_WRDI, 1'b1);
      // address wraps at 24 bits
      page_addr_now = page_addr_now + sfpw_pkg::ADDR_W'(sfpw_pkg::PAGE_BYTES);
      page_pos_now  = 8'd0;
    end else begin
      page_pos_now = page_pos_now + 8'd1;
    end
    pending_bits[pending_bits.size() - 1].last = 1'b1;
  endtask

  // offer one byte after a random gap and wait for its transfer;
  // valid stays high afterwards so back-to-back bytes need no new edge
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= value;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    serialize_byte(value);
    bytes_sent++;
  endtask

  // receiver: random stall before each bit, optional long hold, then check
  initial begin
    int k;
    spi_bit_t want;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        k = hold_request;
        hold_request = 0;
        bit_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      k = steady ? 0 : $urandom_range(0, 3);
      if (k > 0) begin
        bit_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      bit_stall <= 1'b0;
      @(posedge clk);
      while (!bit_valid) @(posedge clk);
      // transfer taken at this edge
      if (pending_bits.size() == 0) begin
        $error("unexpected bit transfer: mosi_bit=%0b frame_end=%0b last=%0b",
               mosi_bit, frame_end, last);
        error_count++;
      end else begin
        want = pending_bits.pop_front();
        if (mosi_bit !== want.mosi) begin
          $error("mosi_bit: expected %0b, got %0b", want.mosi, mosi_bit);
          error_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          error_count++;
        end
      end
    end
  end

  // page opening on an edge value, then mid-page extremes and bit patterns
  task automatic test_byte_extremes();
    logic [7:0] patterns[8] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    foreach (patterns[i]) send_byte(patterns[i]);
  endtask

  // back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (10) send_byte(8'($urandom));
    steady = 1'b0;
  endtask

  // receiver holds off long enough for the input queue to fill and stall
  task automatic test_output_hold();
    hold_request = HOLD_CYCLES;
    repeat (12) send_byte(8'($urandom));
  endtask

  // random page contents across several page closings and openings
  task automatic test_random_pages();
    while (bytes_sent < 315) send_byte(8'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_byte_extremes();
    test_steady_stream();
    test_output_hold();
    test_random_pages();

    data_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    // let any stray bit show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sfpw_pkg.sv
design/sfpw_front.sv
design/sfpw_queue.sv
design/sfpw_back.sv
design/spi_flash_page_writer_unit.sv
tb/testbench.sv
